@@ src/tspt_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch sample pressure tracker package
// Shared types, register map, event codes and the sample conversion function.
// ----------------------------------------------------------------------------
`default_nettype none

package tspt_pkg;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	// Result kinds.
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_PEN_UP = 2'd1,
		EV_POS    = 2'd2
	} event_kind_t;

	// Register indexes (byte address / 4).
	localparam logic [1:0] REG_RESOLUTION = 2'd0;
	localparam logic [1:0] REG_PLATE      = 2'd1;
	localparam logic [1:0] REG_HAS_PEN    = 2'd2;

	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned DIV_STEPS = SAMPLE_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
	localparam int unsigned PROD_W    = 24;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE_LO = 12'h0FF;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE_HI = 12'hFFF;

	// 12-bit mode keeps bits 14..3, 8-bit mode keeps bits 6..0 shifted left once.
	function automatic logic [SAMPLE_W-1:0] convert_word(input logic [15:0] w,
		input logic mode);
		logic [SAMPLE_W-1:0] r;
		if (mode) begin
			r = w[14:3];
		end else begin
			r = {4'b0000, w[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/touch_sample_pressure_tracker.sv @@
// ----------------------------------------------------------------------------
// Touch sample pressure tracker
// An item with a trusted low pen line, a zero x or a zero z1 goes straight
// to the result load; any other item passes through the bit-serial z2/z1
// divider and 2 multiplier steps before its result is loaded. A new item is
// taken only once the last result is loaded into the output register, so an
// earlier result that waits for m_tready holds the input back. Reset clears
// the pen state and output valid, and selects 8-bit mode, zero plate
// resistance and a trusted pen line.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_sample_pressure_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // raw_x[15:0], raw_y[31:16], raw_z1[47:32], raw_z2[63:48]
	input  wire logic [0:0]  s_tuser,  // pen_down_signal[0]
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // touch_started[0], pos_x[12:1], pos_y[24:13],
	                                   // pressure[36:25], pen_is_down[37], zero[39:38]
	output logic      [1:0]  m_tuser   // event_kind[1:0]
);

	localparam int unsigned SW = tspt_pkg::SAMPLE_W;
	localparam int unsigned PW = tspt_pkg::PROD_W;

	tspt_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic          res_mode_q;
	logic [15:0]   plate_q;
	logic          has_pen_q;

	logic          pen_state_q;

	// Item registers.
	logic          force_up_q;
	logic [SW-1:0] x_q, y_q, z1_q;
	logic [SW-1:0] dq_q;   // dividend bits shift out, quotient bits shift in
	logic [SW-1:0] rem_q;
	logic [tspt_pkg::CNT_W-1:0] cnt_q;
	logic [PW-1:0] yp_s1;
	logic [SW-1:0] rt_q;

	// Output registers.
	logic          m_valid_q;
	logic [1:0]    kind_q;
	logic          started_q, pen_out_q;
	logic [SW-1:0] pos_x_q, pos_y_q, press_q;

	logic          take, out_load, cfg_wr;
	logic [SW-1:0] xc, yc, z1c, z2c, full;
	logic [SW:0]   rem_shift, rem_diff;
	logic          q_bit;
	logic [SW+15:0] yp_full;
	logic [PW-1:0] qm1;
	logic [2*PW-1:0] prod;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[3:2])
			tspt_pkg::REG_RESOLUTION: prdata = {31'd0, res_mode_q};
			tspt_pkg::REG_PLATE:      prdata = {16'd0, plate_q};
			tspt_pkg::REG_HAS_PEN:    prdata = {31'd0, has_pen_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_mode_q <= 1'b0;
			plate_q    <= 16'd0;
			has_pen_q  <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tspt_pkg::REG_RESOLUTION: res_mode_q <= pwdata[0];
				tspt_pkg::REG_PLATE:      plate_q    <= pwdata[15:0];
				tspt_pkg::REG_HAS_PEN:    has_pen_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Sample conversion at the input.
	assign full = res_mode_q ? tspt_pkg::FULL_SCALE_HI : tspt_pkg::FULL_SCALE_LO;
	always_comb begin
		xc  = tspt_pkg::convert_word(s_tdata[15:0], res_mode_q);
		yc  = tspt_pkg::convert_word(s_tdata[31:16], res_mode_q);
		z1c = tspt_pkg::convert_word(s_tdata[47:32], res_mode_q);
		z2c = tspt_pkg::convert_word(s_tdata[63:48], res_mode_q);
		if (xc == full) begin
			xc = '0;
		end
	end

	// One restoring divider step per cycle.
	assign rem_shift = {rem_q, dq_q[SW-1]};
	assign rem_diff  = rem_shift - {1'b0, z1_q};
	assign q_bit     = ~rem_diff[SW];

	// Only the low 24 bits of the 28-bit y * plate product reach the result.
	assign yp_full = y_q * plate_q;
	assign qm1     = {{(PW-SW){1'b0}}, dq_q} - PW'(1);
	assign prod    = qm1 * yp_s1;

	always_comb begin
		state_d  = state_q;
		s_tready = (state_q == tspt_pkg::ST_IDLE);
		out_load = 1'b0;
		take     = s_tvalid & s_tready;
		unique case (state_q)
			tspt_pkg::ST_IDLE: begin
				if (take) begin
					if ((has_pen_q && !s_tuser[0]) || xc == '0 || z1c == '0) begin
						state_d = tspt_pkg::ST_DONE;
					end else begin
						state_d = tspt_pkg::ST_DIV;
					end
				end
			end
			tspt_pkg::ST_DIV: begin
				if (cnt_q == tspt_pkg::CNT_W'(tspt_pkg::DIV_STEPS - 1)) begin
					state_d = tspt_pkg::ST_MUL1;
				end
			end
			tspt_pkg::ST_MUL1: state_d = tspt_pkg::ST_MUL2;
			tspt_pkg::ST_MUL2: state_d = tspt_pkg::ST_DONE;
			tspt_pkg::ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = tspt_pkg::ST_IDLE;
				end
			end
			default: state_d = tspt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tspt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (take) begin
			force_up_q <= has_pen_q & ~s_tuser[0];
			x_q        <= xc;
			y_q        <= yc;
			z1_q       <= z1c;
			dq_q       <= z2c;
			rem_q      <= '0;
			cnt_q      <= '0;
			rt_q       <= '0;
		end
		if (state_q == tspt_pkg::ST_DIV) begin
			rem_q <= q_bit ? rem_diff[SW-1:0] : rem_shift[SW-1:0];
			dq_q  <= {dq_q[SW-2:0], q_bit};
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == tspt_pkg::ST_MUL1) begin
			yp_s1 <= yp_full[PW-1:0];
		end
		if (state_q == tspt_pkg::ST_MUL2) begin
			rt_q <= res_mode_q ? prod[23:12] : {4'd0, prod[15:8]};
		end
	end

	// Result and pen state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q   <= 1'b0;
			pen_state_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
			if (force_up_q) begin
				pen_state_q <= 1'b0;
			end else if (rt_q != '0) begin
				pen_state_q <= 1'b1;
			end else if (!has_pen_q) begin
				pen_state_q <= 1'b0;
			end
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			priority if (force_up_q) begin
				kind_q    <= tspt_pkg::EV_PEN_UP;
				started_q <= 1'b0;
				pos_x_q   <= '0;
				pos_y_q   <= '0;
				press_q   <= '0;
				pen_out_q <= 1'b0;
			end else if (rt_q != '0) begin
				kind_q    <= tspt_pkg::EV_POS;
				started_q <= ~pen_state_q;
				pos_x_q   <= x_q;
				pos_y_q   <= y_q;
				press_q   <= rt_q;
				pen_out_q <= 1'b1;
			end else if (!has_pen_q && pen_state_q) begin
				kind_q    <= tspt_pkg::EV_PEN_UP;
				started_q <= 1'b0;
				pos_x_q   <= '0;
				pos_y_q   <= '0;
				press_q   <= '0;
				pen_out_q <= 1'b0;
			end else begin
				kind_q    <= tspt_pkg::EV_NONE;
				started_q <= 1'b0;
				pos_x_q   <= '0;
				pos_y_q   <= '0;
				press_q   <= '0;
				pen_out_q <= pen_state_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {2'b00, pen_out_q, press_q, pos_y_q, pos_x_q, started_q};

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Touch sample pressure tracker testbench
// Drives poll samples into the input stream and configures the block over
// APB. A behavioral predictor keeps its own pen state and register copies,
// works out the report for every accepted item, and the result stream is
// checked in order against those predictions. Both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		tspt_pkg::event_kind_t kind;
		logic        started;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [11:0] pressure;
		logic        pen_down;
	} touch_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// Predictor copies of the registers and of the pen state.
	logic        cfg_hi_res = 1'b0;
	logic [15:0] cfg_plate_ohms = '0;
	logic        cfg_line_trusted = 1'b1;
	logic        pen_touching = 1'b0;

	touch_report_t pending_reports[$];
	int error_count = 0;
	int cycle_count = 0;
	bit idle_off = 1'b0;

	touch_sample_pressure_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH at cycle %0d, %s: got 0x%0h, expected 0x%0h",
			cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic logic [31:0] to_sample(input logic [15:0] w);
		logic [31:0] v;
		v = {16'h0000, w};
		if (cfg_hi_res) begin
			return (v >> 3) & 32'h0FFF;
		end
		return (v << 1) & 32'h00FF;
	endfunction

	function automatic touch_report_t predict_report(input logic pen_line,
		input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] rz1,
		input logic [15:0] rz2);
		touch_report_t r;
		logic [31:0] full, x, y, z1, z2, level;
		r = '0;
		level = '0;
		full = cfg_hi_res ? 32'h0FFF : 32'h00FF;
		// A trusted low pen line ends the touch regardless of the words.
		if (cfg_line_trusted && !pen_line) begin
			pen_touching = 1'b0;
			r.kind = tspt_pkg::EV_PEN_UP;
			return r;
		end
		x = to_sample(rx);
		y = to_sample(ry);
		z1 = to_sample(rz1);
		z2 = to_sample(rz2);
		if (x == full) begin
			x = '0;
		end
		if (x != 0 && z1 != 0) begin
			// Wraps modulo 2^32 when z2 is below z1.
			level = z2 / z1 - 32'd1;
			level = level * (y * {16'h0000, cfg_plate_ohms});
			level = (level >> (cfg_hi_res ? 12 : 8)) & full;
		end
		if (level != 0) begin
			r.kind = tspt_pkg::EV_POS;
			r.started = !pen_touching;
			pen_touching = 1'b1;
			r.pos_x = x[11:0];
			r.pos_y = y[11:0];
			r.pressure = level[11:0];
		end else if (!cfg_line_trusted && pen_touching) begin
			pen_touching = 1'b0;
			r.kind = tspt_pkg::EV_PEN_UP;
		end
		r.pen_down = pen_touching;
		return r;
	endfunction

	task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			report_mismatch($sformatf("register %0d readback", idx), prdata, want);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tspt_pkg::REG_RESOLUTION: begin
				cfg_hi_res = value[0];
				kept = {31'b0, value[0]};
			end
			tspt_pkg::REG_PLATE: begin
				cfg_plate_ohms = value[15:0];
				kept = {16'b0, value[15:0]};
			end
			tspt_pkg::REG_HAS_PEN: begin
				cfg_line_trusted = value[0];
				kept = {31'b0, value[0]};
			end
			default: begin
				kept = '0;
			end
		endcase
		check_register(idx, kept);
	endtask

	task automatic configure(input logic hi_res, input logic [15:0] plate,
		input logic trusted);
		set_register(tspt_pkg::REG_RESOLUTION, {31'b0, hi_res});
		set_register(tspt_pkg::REG_PLATE, {16'b0, plate});
		set_register(tspt_pkg::REG_HAS_PEN, {31'b0, trusted});
	endtask

	// Sends one item; valid stays high on return so back-to-back items need
	// no extra assignment.
	task automatic send_sample(input logic pen_line, input logic [15:0] rx,
		input logic [15:0] ry, input logic [15:0] rz1, input logic [15:0] rz2);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rz2, rz1, ry, rx};
		s_tuser <= pen_line;
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(predict_report(pen_line, rx, ry, rz1, rz2));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 64));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_sample();
		logic [15:0] rx, ry, rz1, rz2;
		logic pen_line;
		pen_line = ($urandom_range(0, 6) != 0);
		rx = random_word();
		ry = random_word();
		rz1 = random_word();
		rz2 = random_word();
		// Now and then set the x sample bits to all ones; only in 12-bit mode is that full scale, which forces x to zero.
		if ($urandom_range(0, 15) == 0) begin
			if (cfg_hi_res) begin
				rx[14:3] = 12'hFFF;
			end else begin
				rx[6:0] = 7'h7F;
			end
		end
		send_sample(pen_line, rx, ry, rz1, rz2);
	endtask

	// Result side: stalls a random number of cycles per item, then checks it.
	initial begin : result_checker
		int stall;
		touch_report_t want;
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
			if (pending_reports.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(m_tuser), 32'd0);
			end else begin
				want = pending_reports.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("event_kind", 32'(m_tuser), 32'(want.kind));
				if (m_tdata[0] !== want.started)
					report_mismatch("touch_started", 32'(m_tdata[0]), 32'(want.started));
				if (m_tdata[12:1] !== want.pos_x)
					report_mismatch("pos_x", 32'(m_tdata[12:1]), 32'(want.pos_x));
				if (m_tdata[24:13] !== want.pos_y)
					report_mismatch("pos_y", 32'(m_tdata[24:13]), 32'(want.pos_y));
				if (m_tdata[36:25] !== want.pressure)
					report_mismatch("pressure", 32'(m_tdata[36:25]), 32'(want.pressure));
				if (m_tdata[37] !== want.pen_down)
					report_mismatch("pen_is_down", 32'(m_tdata[37]), 32'(want.pen_down));
				if (m_tdata[39:38] !== 2'b00)
					report_mismatch("padding bits", 32'(m_tdata[39:38]), 32'd0);
			end
		end
	end

	task automatic test_reset_values();
		check_register(tspt_pkg::REG_RESOLUTION, 32'd0);
		check_register(tspt_pkg::REG_PLATE, 32'd0);
		check_register(tspt_pkg::REG_HAS_PEN, 32'd1);
		// Zero plate resistance and a z1 that converts to zero give zero pressure, hence no position event.
		send_sample(1'b1, 16'h1234, 16'h5678, 16'h0100, 16'h4000);
		send_sample(1'b0, 16'h1234, 16'h5678, 16'h0100, 16'h4000);
		drain_results();
	endtask

	task automatic test_low_resolution();
		configure(1'b0, 16'hFFFF, 1'b1);
		send_sample(1'b1, 16'h0010, 16'h007F, 16'h0001, 16'h0040);
		send_sample(1'b1, 16'h0021, 16'h0013, 16'h0002, 16'h0077);
		send_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// z2 below z1 makes the quotient term wrap.
		send_sample(1'b1, 16'h0011, 16'h0022, 16'h0040, 16'h0001);
		send_sample(1'b1, 16'h0011, 16'h0022, 16'h0000, 16'h0040);
		send_sample(1'b0, 16'h0011, 16'h0022, 16'h0001, 16'h0040);
		send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		drain_results();
	endtask

	task automatic test_high_resolution();
		configure(1'b1, 16'hFFFF, 1'b1);
		send_sample(1'b1, 16'h7FF8, 16'h4000, 16'h0100, 16'h8000);
		send_sample(1'b1, 16'hFFFF, 16'h4000, 16'h0100, 16'h8000);
		send_sample(1'b1, 16'h0008, 16'hFFFF, 16'h0008, 16'hFFFF);
		send_sample(1'b1, 16'h8000, 16'h1000, 16'h0100, 16'h8000);
		send_sample(1'b1, 16'h1230, 16'h0450, 16'h7000, 16'h0010);
		send_sample(1'b0, 16'h1230, 16'h0450, 16'h0010, 16'h7000);
		drain_results();
	endtask

	task automatic test_untrusted_line();
		configure(1'b1, 16'd1000, 1'b0);
		send_sample(1'b0, 16'h1000, 16'h2000, 16'h0040, 16'h4000);
		send_sample(1'b1, 16'h1000, 16'h2000, 16'h0000, 16'h4000);
		send_sample(1'b0, 16'h1000, 16'h2000, 16'h0000, 16'h4000);
		send_sample(1'b1, 16'h0800, 16'h0800, 16'h0080, 16'hFFF0);
		send_sample(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		drain_results();
	endtask

	task automatic test_random_traffic();
		logic [15:0] plate;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase % 4)
				0: plate = 16'hFFFF;
				1: plate = 16'($urandom);
				2: plate = 16'($urandom_range(1, 16));
				default: plate = 16'h0000;
			endcase
			configure(phase[0], plate, (phase % 3) != 2);
			idle_off = (phase == 3);
			for (int n = 0; n < 100; n++) begin
				// Hold the input back once until every report is out.
				if (phase == 6 && n == 50) begin
					drain_results();
				end
				send_random_sample();
			end
			drain_results();
			idle_off = 1'b0;
		end
	endtask

	initial begin : main_sequence
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_low_resolution();
		test_high_resolution();
		test_untrusted_line();
		test_random_traffic();
		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_reports.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
